>>> sv/fhs_pkg.sv
// Shared types, constants and helpers for the floppy head stepper controller.
package fhs_pkg;

    // Geometry and drive count
    localparam int QUARTER_TRACKS = 160;
    localparam int DRIVES         = 2;

    // Field widths
    localparam int POS_W    = 8;
    localparam int LVL_W    = 24;
    localparam int CYC_W    = 20;
    localparam int STEP_W   = 16;
    localparam int SETTLE_W = 16;
    localparam int PROD_W   = STEP_W + CYC_W;
    localparam int CFG_W    = 24;
    localparam int IDX_W    = 3;

    localparam logic [LVL_W-1:0] FULL_LEVEL = 24'hFFFFFF;
    localparam logic [3:0]       NIB_MASK   = 4'hF;

    // Command codes
    localparam logic [1:0] CMD_PHASE  = 2'd0;
    localparam logic [1:0] CMD_MOTOR  = 2'd1;
    localparam logic [1:0] CMD_SELECT = 2'd2;
    localparam logic [1:0] CMD_CHECK  = 2'd3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_SETTLE_CYCLES  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SPINUP_STEP    = 3'd1;
    localparam logic [IDX_W-1:0] REG_SPINDOWN_STEP  = 3'd2;
    localparam logic [IDX_W-1:0] REG_READABLE_LEVEL = 3'd3;
    localparam logic [IDX_W-1:0] REG_DISK_PRESENT   = 3'd4;

    // Configuration reset values
    localparam logic [SETTLE_W-1:0] RST_SETTLE_CYCLES  = 16'd3069;
    localparam logic [STEP_W-1:0]   RST_SPINUP_STEP    = 16'd41;
    localparam logic [STEP_W-1:0]   RST_SPINDOWN_STEP  = 16'd16;
    localparam logic [LVL_W-1:0]    RST_READABLE_LEVEL = 24'd11184810;
    localparam logic [1:0]          RST_DISK_PRESENT   = 2'd0;

    // Command queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [SETTLE_W-1:0] settle_cycles;
        logic [STEP_W-1:0]   spinup_step;
        logic [STEP_W-1:0]   spindown_step;
        logic [LVL_W-1:0]    readable_level;
        logic [1:0]          disk_present;
    } cfg_t;

    // Classified command as carried from front to back
    typedef struct packed {
        logic              is_phase;
        logic              is_motor;
        logic              is_select;
        logic [3:0]        coil_mask;
        logic              code_bit;
        logic [CYC_W-1:0]  cyc;
        logic [PROD_W-1:0] up_amt;
        logic [PROD_W-1:0] dn_amt;
    } op_t;

    function automatic logic [3:0] rot_left4(input logic [3:0] x);
        rot_left4 = {x[2:0], x[3]} & NIB_MASK;
    endfunction

    function automatic logic [3:0] rot_right4(input logic [3:0] x);
        rot_right4 = {x[0], x[3:1]} & NIB_MASK;
    endfunction

endpackage

>>> sv/fhs_front.sv
// Front end: accepts transactions, decodes the command and scales the speed ramps.
module fhs_front import fhs_pkg::*; (
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_cmd,
    input  logic [2:0]       s_switch_code,
    input  logic [CYC_W-1:0] s_elapsed_cycles,
    input  cfg_t             cfg,
    input  logic             q_full,
    output logic             q_push,
    output op_t              q_data
);

    // Accept whenever the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Command decode
    always_comb begin
        q_data.is_phase  = 1'b0;
        q_data.is_motor  = 1'b0;
        q_data.is_select = 1'b0;
        case (s_cmd)
            CMD_PHASE:  q_data.is_phase  = 1'b1;
            CMD_MOTOR:  q_data.is_motor  = 1'b1;
            CMD_SELECT: q_data.is_select = 1'b1;
            CMD_CHECK:  ;
            default:    ;
        endcase
        q_data.coil_mask = 4'b0001 << s_switch_code[2:1];
        q_data.code_bit  = s_switch_code[0];
        q_data.cyc       = s_elapsed_cycles;
        // Ramp amounts over the elapsed interval
        q_data.up_amt    = PROD_W'(cfg.spinup_step) * PROD_W'(s_elapsed_cycles);
        q_data.dn_amt    = PROD_W'(cfg.spindown_step) * PROD_W'(s_elapsed_cycles);
    end

endmodule

>>> sv/fhs_queue.sv
// Short FIFO of classified commands between front and back.
module fhs_queue import fhs_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  op_t  push_data,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output op_t  head_data
);

    op_t               mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/fhs_back.sv
// Back end: per-drive state, head stepping, spindle ramp and the result register.
module fhs_back import fhs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             op_valid,
    input  op_t              op,
    output logic             op_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [POS_W-1:0] m_quarter_track,
    output logic             m_head_moved,
    output logic             m_head_settled,
    output logic             m_read_ready,
    output logic             m_active_drive
);

    // Drive state
    logic                sel_reg, sel_next;
    logic [3:0]          phase_reg  [2];
    logic [3:0]          phase_next [2];
    logic [3:0]          last_reg   [2];
    logic [3:0]          last_next  [2];
    logic [POS_W-1:0]    pos_reg    [2];
    logic [POS_W-1:0]    pos_next   [2];
    logic [SETTLE_W-1:0] settle_reg [2];
    logic [SETTLE_W-1:0] settle_next[2];
    logic                motor_reg  [2];
    logic                motor_next [2];
    logic [LVL_W-1:0]    lvl_reg    [2];
    logic [LVL_W-1:0]    lvl_next   [2];

    // Result register
    logic             m_valid_reg;
    logic [POS_W-1:0] quarter_track_reg;
    logic             head_moved_reg, head_settled_reg, read_ready_reg, active_drive_reg;

    logic fire;

    // Phase step decode for the selected drive
    logic [3:0]       cur_phase, prev_phase;
    logic [2:0]       n_on;
    logic             fwd, bwd, moved;
    logic [1:0]       step_mag;
    logic signed [9:0] pos_sum, pos_fix;
    logic             ready_now;

    assign fire   = op_valid && (!m_valid_reg || m_ready);
    assign op_pop = fire;

    always_comb begin
        prev_phase = last_reg[sel_reg];
        cur_phase  = op.code_bit ? (phase_reg[sel_reg] | op.coil_mask)
                                 : (phase_reg[sel_reg] & ~op.coil_mask & NIB_MASK);
        n_on       = 3'($countones(cur_phase));
        fwd        = |(cur_phase & rot_left4(prev_phase));
        bwd        = |(cur_phase & rot_right4(prev_phase));
        step_mag   = (n_on == 3'd1) ? 2'd2 : 2'd1;
        pos_sum    = fwd ? $signed({2'b00, pos_reg[sel_reg]}) + $signed({8'd0, step_mag})
                         : $signed({2'b00, pos_reg[sel_reg]}) - $signed({8'd0, step_mag});
        // Clamp low, snap single-phase to even, then clamp high
        pos_fix = pos_sum;
        if (pos_sum < 0) begin
            pos_fix = '0;
        end else if (n_on == 3'd1) begin
            pos_fix[0] = 1'b0;
        end
        if (pos_fix >= $signed(10'(QUARTER_TRACKS))) begin
            pos_fix = $signed(10'(QUARTER_TRACKS - 1));
        end
        moved = op.is_phase && (cur_phase != phase_reg[sel_reg])
                && (n_on == 3'd1 || n_on == 3'd2) && (fwd || bwd);
    end

    // Next drive state
    always_comb begin
        sel_next = sel_reg;
        for (int d = 0; d < 2; d++) begin
            phase_next[d]  = phase_reg[d];
            last_next[d]   = last_reg[d];
            pos_next[d]    = pos_reg[d];
            settle_next[d] = settle_reg[d];
            motor_next[d]  = motor_reg[d];
            lvl_next[d]    = lvl_reg[d];
        end
        if (fire) begin
            // Advance every drive over the elapsed interval
            for (int d = 0; d < DRIVES; d++) begin
                if ({4'd0, settle_reg[d]} > op.cyc) begin
                    settle_next[d] = SETTLE_W'({4'd0, settle_reg[d]} - op.cyc);
                end else begin
                    settle_next[d] = '0;
                end
                if (motor_reg[d]) begin
                    if ({13'd0, lvl_reg[d]} + {1'b0, op.up_amt} > {13'd0, FULL_LEVEL}) begin
                        lvl_next[d] = FULL_LEVEL;
                    end else begin
                        lvl_next[d] = lvl_reg[d] + op.up_amt[LVL_W-1:0];
                    end
                end else begin
                    if ({12'd0, lvl_reg[d]} > op.dn_amt) begin
                        lvl_next[d] = lvl_reg[d] - op.dn_amt[LVL_W-1:0];
                    end else begin
                        lvl_next[d] = '0;
                    end
                end
            end
            // Apply the command to the selected drive
            if (op.is_phase && (cur_phase != phase_reg[sel_reg])) begin
                phase_next[sel_reg] = cur_phase;
                if (n_on == 3'd1 || n_on == 3'd2) begin
                    last_next[sel_reg] = cur_phase;
                    if (fwd || bwd) begin
                        settle_next[sel_reg] = cfg.settle_cycles;
                        pos_next[sel_reg]    = pos_fix[POS_W-1:0];
                    end
                end
            end
            if (op.is_motor) begin
                motor_next[sel_reg] = op.code_bit;
            end
            if (op.is_select && (int'(op.code_bit) < DRIVES)) begin
                sel_next = op.code_bit;
            end
        end
    end

    assign ready_now = (settle_next[sel_next] == '0)
                       && (lvl_next[sel_next] >= cfg.readable_level)
                       && cfg.disk_present[sel_next];

    // State and handshake registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int d = 0; d < 2; d++) begin
                phase_reg[d]  <= '0;
                last_reg[d]   <= '0;
                pos_reg[d]    <= '0;
                settle_reg[d] <= '0;
                motor_reg[d]  <= 1'b0;
                lvl_reg[d]    <= '0;
            end
        end else begin
            sel_reg <= sel_next;
            for (int d = 0; d < 2; d++) begin
                phase_reg[d]  <= phase_next[d];
                last_reg[d]   <= last_next[d];
                pos_reg[d]    <= pos_next[d];
                settle_reg[d] <= settle_next[d];
                motor_reg[d]  <= motor_next[d];
                lvl_reg[d]    <= lvl_next[d];
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (fire) begin
            quarter_track_reg <= pos_next[sel_next];
            head_moved_reg    <= moved;
            head_settled_reg  <= (settle_next[sel_next] == '0);
            read_ready_reg    <= ready_now;
            active_drive_reg  <= sel_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_quarter_track = quarter_track_reg;
    assign m_head_moved    = head_moved_reg;
    assign m_head_settled  = head_settled_reg;
    assign m_read_ready    = read_ready_reg;
    assign m_active_drive  = active_drive_reg;

endmodule

>>> sv/floppy_head_stepper_motor_ctrl_unit.sv
// Top level of the floppy head stepper and spindle controller.
// The queue registers each accepted transaction; the back end registers its result.
// Throughput: one transaction per cycle unless the result side stalls (m_ready low).
// A four-entry command queue lets the input keep accepting while a result waits.
// Reset (aresetn low, synchronous) clears all drive state, the queue and the
// result valid flag, and loads the configuration registers with their defaults.
module floppy_head_stepper_motor_ctrl_unit import fhs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_cmd,
    input  logic [2:0]       s_switch_code,
    input  logic [CYC_W-1:0] s_elapsed_cycles,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [POS_W-1:0] m_quarter_track,
    output logic             m_head_moved,
    output logic             m_head_settled,
    output logic             m_read_ready,
    output logic             m_active_drive,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0] cfg_wdata
);

    cfg_t cfg_reg;
    logic q_full, q_push, q_pop, q_head_valid;
    op_t  q_in, q_head;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.settle_cycles  <= RST_SETTLE_CYCLES;
            cfg_reg.spinup_step    <= RST_SPINUP_STEP;
            cfg_reg.spindown_step  <= RST_SPINDOWN_STEP;
            cfg_reg.readable_level <= RST_READABLE_LEVEL;
            cfg_reg.disk_present   <= RST_DISK_PRESENT;
        end else if (cfg_wr_en) begin
            case (cfg_idx)
                REG_SETTLE_CYCLES:  cfg_reg.settle_cycles  <= cfg_wdata[SETTLE_W-1:0];
                REG_SPINUP_STEP:    cfg_reg.spinup_step    <= cfg_wdata[STEP_W-1:0];
                REG_SPINDOWN_STEP:  cfg_reg.spindown_step  <= cfg_wdata[STEP_W-1:0];
                REG_READABLE_LEVEL: cfg_reg.readable_level <= cfg_wdata[LVL_W-1:0];
                REG_DISK_PRESENT:   cfg_reg.disk_present   <= cfg_wdata[1:0];
                default:            ;
            endcase
        end
    end

    fhs_front u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_switch_code    (s_switch_code),
        .s_elapsed_cycles (s_elapsed_cycles),
        .cfg              (cfg_reg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_data           (q_in)
    );

    fhs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head)
    );

    fhs_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .op_valid        (q_head_valid),
        .op              (q_head),
        .op_pop          (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_quarter_track (m_quarter_track),
        .m_head_moved    (m_head_moved),
        .m_head_settled  (m_head_settled),
        .m_read_ready    (m_read_ready),
        .m_active_drive  (m_active_drive)
    );

endmodule

>>> sv/fhs_checker.sv
// Port-level checks for the stepper controller, bound to the top level.
module fhs_checker import fhs_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [POS_W-1:0] m_quarter_track,
    input logic             m_head_moved,
    input logic             m_head_settled,
    input logic             m_read_ready,
    input logic             m_active_drive
);

    // Transactions accepted but not yet delivered
    logic [3:0] pending_reg, pending_next;

    always_comb begin
        pending_next = pending_reg;
        if ((s_valid && s_ready) && !(m_valid && m_ready)) begin
            pending_next = pending_reg + 1'b1;
        end else if (!(s_valid && s_ready) && (m_valid && m_ready)) begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // No result without an accepted transaction behind it
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pending_reg != '0))
        else $error("result shown with no pending transaction");

    // Head position stays on the disk
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_quarter_track < POS_W'(QUARTER_TRACKS)))
        else $error("quarter track out of range");

    // Read readiness requires a settled head
    a_ready_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_read_ready) |-> m_head_settled)
        else $error("read ready while head not settled");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_quarter_track)
            && $stable(m_head_moved) && $stable(m_head_settled)
            && $stable(m_read_ready) && $stable(m_active_drive)))
        else $error("stalled result changed");

endmodule

bind floppy_head_stepper_motor_ctrl_unit fhs_checker u_fhs_checker (.*);

>>> sim/testbench.sv
// Self-checking testbench for the floppy head stepper and spindle controller.
module testbench;
    import fhs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Expected contents of one result transaction
    typedef struct {
        logic [POS_W-1:0] quarter_track;
        logic             head_moved;
        logic             head_settled;
        logic             read_ready;
        logic             active_drive;
    } track_result_t;

    logic             aclk;
    logic             aresetn          = 1'b0;
    logic             s_valid          = 1'b0;
    logic             s_ready;
    logic [1:0]       s_cmd            = CMD_CHECK;
    logic [2:0]       s_switch_code    = '0;
    logic [CYC_W-1:0] s_elapsed_cycles = '0;
    logic             m_valid;
    logic             m_ready          = 1'b0;
    logic [POS_W-1:0] m_quarter_track;
    logic             m_head_moved;
    logic             m_head_settled;
    logic             m_read_ready;
    logic             m_active_drive;
    logic             cfg_wr_en        = 1'b0;
    logic [IDX_W-1:0] cfg_idx          = '0;
    logic [CFG_W-1:0] cfg_wdata        = '0;

    floppy_head_stepper_motor_ctrl_unit u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_switch_code    (s_switch_code),
        .s_elapsed_cycles (s_elapsed_cycles),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_quarter_track  (m_quarter_track),
        .m_head_moved     (m_head_moved),
        .m_head_settled   (m_head_settled),
        .m_read_ready     (m_read_ready),
        .m_active_drive   (m_active_drive),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_idx          (cfg_idx),
        .cfg_wdata        (cfg_wdata)
    );

    // Predicted configuration
    logic [SETTLE_W-1:0] settle_load   = RST_SETTLE_CYCLES;
    logic [STEP_W-1:0]   spinup_rate   = RST_SPINUP_STEP;
    logic [STEP_W-1:0]   spindown_rate = RST_SPINDOWN_STEP;
    logic [LVL_W-1:0]    ready_level   = RST_READABLE_LEVEL;
    logic [1:0]          disk_mask     = RST_DISK_PRESENT;

    // Predicted drive state
    logic                sel_drive = 1'b0;
    logic [3:0]          coils_on[2]    = '{default: '0};
    logic [3:0]          coils_last[2]  = '{default: '0};
    logic [POS_W-1:0]    head_qtrack[2] = '{default: '0};
    logic [SETTLE_W-1:0] settle_left[2] = '{default: '0};
    logic                spindle_on[2]  = '{default: 1'b0};
    logic [LVL_W-1:0]    spin_level[2]  = '{default: '0};

    track_result_t pending_results[$];
    int            mismatch_count = 0;
    bit            idle_enable    = 1'b1;
    bit            seek_fwd       = 1'b1;
    int            stall_left     = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Track the register file as the block sees it
    function automatic void apply_register(input logic [IDX_W-1:0] idx,
                                           input logic [CFG_W-1:0] value);
        case (idx)
            REG_SETTLE_CYCLES:  settle_load   = value[SETTLE_W-1:0];
            REG_SPINUP_STEP:    spinup_rate   = value[STEP_W-1:0];
            REG_SPINDOWN_STEP:  spindown_rate = value[STEP_W-1:0];
            REG_READABLE_LEVEL: ready_level   = value[LVL_W-1:0];
            REG_DISK_PRESENT:   disk_mask     = value[1:0];
            default: ;
        endcase
    endfunction

    // Apply a phase switch to drive d; returns 1 when the head stepped
    function automatic bit step_head(input int d, input logic [2:0] code);
        logic [3:0] coil;
        logic [3:0] now_on;
        logic [3:0] prev;
        int         n;
        int         delta;
        int         pos;
        coil   = 4'b0001 << code[2:1];
        now_on = code[0] ? (coils_on[d] | coil) : (coils_on[d] & ~coil);
        prev   = coils_last[d];
        if (now_on == coils_on[d]) return 1'b0;
        n = $countones(now_on);
        // no magnet or three and more: coils change, head stays
        if (n == 0 || n > 2) begin
            coils_on[d] = now_on;
            return 1'b0;
        end
        delta = (n == 1) ? 2 : 1;
        if ((now_on & {prev[2:0], prev[3]}) != 0) begin
            // pulled forward
        end else if ((now_on & {prev[0], prev[3:1]}) != 0) begin
            delta = -delta;
        end else begin
            coils_on[d]   = now_on;
            coils_last[d] = now_on;
            return 1'b0;
        end
        settle_left[d] = settle_load;
        pos = int'(head_qtrack[d]) + delta;
        if (pos < 0) pos = 0;
        else if (n == 1) pos = pos & -2;
        if (pos >= QUARTER_TRACKS) pos = QUARTER_TRACKS - 1;
        head_qtrack[d] = pos[POS_W-1:0];
        coils_on[d]    = now_on;
        coils_last[d]  = now_on;
        return 1'b1;
    endfunction

    // Advance both drives, run the command, and form the result
    function automatic track_result_t predict_track(input logic [1:0] cmd,
                                                    input logic [2:0] code,
                                                    input logic [CYC_W-1:0] cyc);
        track_result_t    res;
        longint unsigned  lvl;
        longint unsigned  amount;
        bit               moved;
        int               d;
        moved = 1'b0;
        for (int k = 0; k < DRIVES; k++) begin
            if (settle_left[k] > cyc) settle_left[k] = settle_left[k] - cyc[SETTLE_W-1:0];
            else settle_left[k] = '0;
            lvl = spin_level[k];
            if (spindle_on[k]) begin
                lvl = lvl + longint'(spinup_rate) * longint'(cyc);
                if (lvl > FULL_LEVEL) lvl = FULL_LEVEL;
            end else begin
                amount = longint'(spindown_rate) * longint'(cyc);
                lvl = (lvl > amount) ? lvl - amount : 0;
            end
            spin_level[k] = lvl[LVL_W-1:0];
        end
        d = sel_drive;
        case (cmd)
            CMD_PHASE:  moved = step_head(d, code);
            CMD_MOTOR:  spindle_on[d] = code[0];
            CMD_SELECT: if (int'(code[0]) < DRIVES) sel_drive = code[0];
            default: ;
        endcase
        d = sel_drive;
        res.quarter_track = head_qtrack[d];
        res.head_moved    = moved;
        res.head_settled  = (settle_left[d] == 0);
        res.read_ready    = (settle_left[d] == 0) && (spin_level[d] >= ready_level)
                            && disk_mask[d];
        res.active_drive  = sel_drive;
        return res;
    endfunction

    // Send one transaction, with an occasional gap in front of it
    task automatic send_item(input logic [1:0] cmd, input logic [2:0] code,
                             input logic [CYC_W-1:0] cyc);
        int gap;
        gap = (idle_enable && $urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid          <= 1'b1;
        s_cmd            <= cmd;
        s_switch_code    <= code;
        s_elapsed_cycles <= cyc;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_track(cmd, code, cyc));
    endtask

    // Stop sending and let every outstanding result come back
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        apply_register(idx, value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_registers(input logic [SETTLE_W-1:0] settle,
                                 input logic [STEP_W-1:0] up, input logic [STEP_W-1:0] down,
                                 input logic [LVL_W-1:0] level, input logic [1:0] disks);
        write_reg(REG_SETTLE_CYCLES, CFG_W'(settle));
        write_reg(REG_SPINUP_STEP, CFG_W'(up));
        write_reg(REG_SPINDOWN_STEP, CFG_W'(down));
        write_reg(REG_READABLE_LEVEL, CFG_W'(level));
        write_reg(REG_DISK_PRESENT, CFG_W'(disks));
    endtask

    // Next coil change that walks the selected head one way
    function automatic logic [2:0] seek_code(input bit fwd);
        logic [3:0] ph;
        logic [1:0] lo;
        ph = coils_on[sel_drive];
        lo = '0;
        if ($countones(ph) == 1) begin
            for (int k = 0; k < 4; k++) if (ph[k]) lo = k[1:0];
            return fwd ? {lo + 2'd1, 1'b1} : {lo - 2'd1, 1'b1};
        end
        if ($countones(ph) == 2) begin
            for (int k = 0; k < 4; k++) begin
                if (ph[k] && ph[(k + 1) % 4]) begin
                    lo = k[1:0];
                    return fwd ? {lo, 1'b0} : {lo + 2'd1, 1'b0};
                end
            end
        end
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic logic [CYC_W-1:0] random_elapsed();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) return '0;
        if (pick < 55) return CYC_W'($urandom_range(1, 400));
        if (pick < 85) return CYC_W'($urandom_range(0, 4000));
        return CYC_W'($urandom);
    endfunction

    // Mostly head seeks with random timing, mixed with motor, select and check traffic
    task automatic send_random_item();
        logic [1:0] cmd;
        logic [2:0] code;
        int         pick;
        pick = $urandom_range(0, 99);
        code = 3'($urandom_range(0, 7));
        if (pick < 70) begin
            cmd = CMD_PHASE;
            if ($urandom_range(0, 4) != 0) code = seek_code(seek_fwd);
        end else if (pick < 80) begin
            cmd = CMD_MOTOR;
        end else if (pick < 88) begin
            cmd = CMD_SELECT;
        end else begin
            cmd = CMD_CHECK;
        end
        if ($urandom_range(0, 39) == 0) seek_fwd = ~seek_fwd;
        send_item(cmd, code, random_elapsed());
    endtask

    // Result side: random stall bursts while idling is on
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 11);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : check_results
        track_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no prediction outstanding");
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("quarter_track", want.quarter_track, m_quarter_track);
                check_field("head_moved", want.head_moved, m_head_moved);
                check_field("head_settled", want.head_settled, m_head_settled);
                check_field("read_ready", want.read_ready, m_read_ready);
                check_field("active_drive", want.active_drive, m_active_drive);
            end
        end
    end

    // Outputs straight after reset
    task automatic test_reset_state();
        send_item(CMD_CHECK, 3'd0, '0);
        send_item(CMD_CHECK, 3'd7, '0);
    endtask

    // Coil patterns: backward moves clamped at zero, single-phase snap,
    // unchanged coils, three magnets, none on, and non-adjacent patterns
    task automatic test_phase_patterns();
        send_item(CMD_PHASE, 3'd1, 20'd5);
        send_item(CMD_PHASE, 3'd7, '0);
        send_item(CMD_PHASE, 3'd0, 20'd100);
        send_item(CMD_PHASE, 3'd1, 20'hFFFFF);
        send_item(CMD_PHASE, 3'd6, 20'd3068);
        send_item(CMD_PHASE, 3'd3, 20'd3069);
        send_item(CMD_PHASE, 3'd3, 20'd1);
        send_item(CMD_PHASE, 3'd5, 20'd10);
        send_item(CMD_PHASE, 3'd0, '0);
        send_item(CMD_PHASE, 3'd2, 20'd7);
        send_item(CMD_PHASE, 3'd4, 20'd7);
        send_item(CMD_PHASE, 3'd1, '0);
        send_item(CMD_PHASE, 3'd5, '0);
    endtask

    // Spin-up to full scale, spin-down to zero, readiness and the second drive
    task automatic test_motor_and_speed();
        send_item(CMD_MOTOR, 3'd1, '0);
        send_item(CMD_CHECK, 3'd0, 20'd1000);
        send_item(CMD_CHECK, 3'd0, 20'hFFFFF);
        write_reg(REG_DISK_PRESENT, CFG_W'(2'b11));
        send_item(CMD_CHECK, 3'd0, 20'd4000);
        send_item(CMD_SELECT, 3'd1, '0);
        send_item(CMD_MOTOR, 3'd3, 20'hFFFFF);
        send_item(CMD_MOTOR, 3'd6, 20'd2);
        send_item(CMD_CHECK, 3'd0, 20'hFFFFF);
        send_item(CMD_SELECT, 3'd4, 20'd1);
        send_item(CMD_MOTOR, 3'd0, 20'd50);
    endtask

    // Walk the head into the outer stop and back to track zero
    task automatic test_seek_to_stops();
        int guard;
        guard = 0;
        while (head_qtrack[sel_drive] != QUARTER_TRACKS - 1 && guard < 600) begin
            send_item(CMD_PHASE, seek_code(1'b1), CYC_W'($urandom_range(0, 200)));
            guard++;
        end
        repeat (6) send_item(CMD_PHASE, seek_code(1'b1), CYC_W'($urandom_range(0, 200)));
        guard = 0;
        while (head_qtrack[sel_drive] != 0 && guard < 600) begin
            send_item(CMD_PHASE, seek_code(1'b0), CYC_W'($urandom_range(0, 200)));
            guard++;
        end
        repeat (6) send_item(CMD_PHASE, seek_code(1'b0), CYC_W'($urandom_range(0, 200)));
    endtask

    task automatic run_traffic(input int count, input bit idling);
        idle_enable = idling;
        repeat (count) send_random_item();
    endtask

    // Random traffic under a series of register settings, extremes included
    task automatic test_register_sweep();
        set_registers('0, '0, '0, '0, 2'b11);
        run_traffic(90, 1'b1);
        set_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 2'b01);
        run_traffic(90, 1'b1);
        set_registers(SETTLE_W'($urandom), STEP_W'($urandom), STEP_W'($urandom),
                      LVL_W'($urandom), 2'b10);
        run_traffic(90, 1'b0);
        set_registers(SETTLE_W'($urandom_range(0, 500)), STEP_W'($urandom_range(1000, 65535)),
                      STEP_W'($urandom_range(0, 65535)), LVL_W'($urandom), 2'b11);
        run_traffic(90, 1'b1);
        set_registers(RST_SETTLE_CYCLES, RST_SPINUP_STEP, RST_SPINDOWN_STEP,
                      RST_READABLE_LEVEL, 2'b11);
        run_traffic(90, 1'b1);
        set_registers(SETTLE_W'($urandom_range(0, 4000)), STEP_W'($urandom),
                      STEP_W'($urandom), LVL_W'($urandom), 2'($urandom_range(0, 3)));
        run_traffic(90, 1'b0);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_phase_patterns();
        test_motor_and_speed();
        test_seek_to_stops();
        test_register_sweep();
        // drain outstanding results, then allow for the pipeline depth
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
